/* rtl/chn_pkg.sv */
// ----------------------------------------------------------------------------
// chn_pkg: shared types and constants for the CAN handshake node emulator
// Holds the mode encoding, handshake codes, reset values and the structs
// passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package chn_pkg;

    localparam int NODE_COUNT_DEF = 128;

    localparam logic [10:0] FUNC_MASK      = 11'h780;
    localparam logic [10:0] FUNC_HANDSHAKE = 11'h480;

    localparam logic [7:0]  TAG_ANNOUNCE   = 8'h01;
    localparam logic [7:0]  TAG_START      = 8'h02;
    localparam logic [7:0]  TAG_ANN_ACK    = 8'h12;
    localparam logic [7:0]  TAG_STEADY     = 8'h52;

    localparam logic [7:0]  COUNT_THRESHOLD = 8'd2;
    localparam logic [15:0] PERIOD_RESET    = 16'd1000;
    localparam logic [6:0]  NODE_RESET      = 7'd98;
    localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_NODE   = 1'b1;

    typedef enum logic [2:0] {
        MODE_POWERING  = 3'b001,
        MODE_ANNOUNCED = 3'b010,
        MODE_STEADY    = 3'b100
    } mode_t;

    typedef struct packed {
        logic       emit;
        logic [6:0] sender;
        logic [7:0] next_node;
        logic [7:0] tag;
        logic       ready;
    } frame_t;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  ctrl_node;
        logic [7:0]  count;
        logic [15:0] elapsed;
        logic        map_bit;
        logic        in_range;
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  ctrl_node;
        logic [7:0]  count;
        logic [15:0] elapsed;
        logic        map_wr;
        logic        map_val;
        frame_t      frame;
    } upd_t;

endpackage

/* rtl/chn_step.sv */
// ----------------------------------------------------------------------------
// chn_step: handshake decision logic for one item
// Works out the next mode, controller node, map and count update, timer
// value and the requested frame from the current state and one item.
// ----------------------------------------------------------------------------
module chn_step
(
    input  logic             action,
    input  logic [10:0]      frame_id,
    input  logic [7:0]       first_byte,
    input  logic [7:0]       second_byte,
    input  logic             bus_idle,
    input  chn_pkg::state_t  st,
    input  logic [15:0]      handshake_period,
    input  logic [6:0]       emulated_node,
    output chn_pkg::upd_t    upd
);

    // frame that opens a new handshake from the given mode
    function automatic chn_pkg::frame_t start_frame(input chn_pkg::mode_t m,
                                                    input logic [6:0] emu);
        chn_pkg::frame_t f;
        f = '0;
        unique case (m)
            chn_pkg::MODE_POWERING:
            begin
                f.emit      = 1'b1;
                f.sender    = 7'd0;
                f.next_node = 8'd0;
                f.tag       = chn_pkg::TAG_ANNOUNCE;
                f.ready     = 1'b0;
            end
            chn_pkg::MODE_ANNOUNCED, chn_pkg::MODE_STEADY:
            begin
                f.emit      = 1'b1;
                f.sender    = 7'd0;
                f.next_node = {1'b0, emu};
                f.tag       = chn_pkg::TAG_START;
                f.ready     = 1'b1;
            end
            default:
            begin
                f = '0;
            end
        endcase
        return f;
    endfunction

    logic [6:0]  node;
    logic [15:0] elapsed_inc;
    logic        is_handshake;
    logic        announce;
    logic        steady_tag;
    logic        tagged_me;

    assign node         = frame_id[6:0];
    assign elapsed_inc  = (st.elapsed == chn_pkg::ELAPSED_MAX) ? st.elapsed
                                                               : st.elapsed + 16'd1;
    assign is_handshake = (frame_id & chn_pkg::FUNC_MASK) == chn_pkg::FUNC_HANDSHAKE;
    assign announce     = ({1'b0, node} == first_byte) && (second_byte == chn_pkg::TAG_ANNOUNCE);
    assign steady_tag   = (first_byte == 8'd0) &&
                          ((second_byte == chn_pkg::TAG_ANN_ACK) ||
                           (second_byte == chn_pkg::TAG_STEADY));
    assign tagged_me    = first_byte == {1'b0, emulated_node};

    always_comb
    begin
        logic done;
        logic bit_mid;
        done          = 1'b0;
        bit_mid       = st.map_bit;
        upd.mode      = st.mode;
        upd.ctrl_node = st.ctrl_node;
        upd.count     = st.count;
        upd.elapsed   = st.elapsed;
        upd.map_wr    = 1'b0;
        upd.map_val   = 1'b0;
        upd.frame     = '0;

        if (action)
        begin
            upd.elapsed = elapsed_inc;
            if (bus_idle && (elapsed_inc > handshake_period))
            begin
                upd.frame = start_frame(st.mode, emulated_node);
            end
        end
        else if (is_handshake)
        begin
            if ((node != 7'd0) && (node != emulated_node))
            begin
                upd.ctrl_node = node;
            end

            if (announce)
            begin
                if (st.in_range && !st.map_bit)
                begin
                    upd.map_wr  = 1'b1;
                    upd.map_val = 1'b1;
                    bit_mid     = 1'b1;
                    upd.count   = st.count + 8'd1;
                end
                if (upd.count > chn_pkg::COUNT_THRESHOLD)
                begin
                    upd.mode  = chn_pkg::MODE_ANNOUNCED;
                    upd.frame = start_frame(chn_pkg::MODE_ANNOUNCED, emulated_node);
                    done      = 1'b1;
                end
            end

            if (!done)
            begin
                if (steady_tag)
                begin
                    if (st.mode != chn_pkg::MODE_STEADY)
                    begin
                        upd.mode  = chn_pkg::MODE_STEADY;
                        upd.frame = start_frame(chn_pkg::MODE_STEADY, emulated_node);
                    end
                end
                else
                begin
                    unique case (st.mode)
                        chn_pkg::MODE_POWERING:
                        begin
                            if (node == 7'd0)
                            begin
                                upd.frame.emit      = 1'b1;
                                upd.frame.sender    = emulated_node;
                                upd.frame.next_node = {1'b0, emulated_node};
                                upd.frame.tag       = chn_pkg::TAG_ANNOUNCE;
                                upd.frame.ready     = 1'b0;
                            end
                        end
                        chn_pkg::MODE_ANNOUNCED:
                        begin
                            if (tagged_me)
                            begin
                                upd.frame.emit      = 1'b1;
                                upd.frame.sender    = emulated_node;
                                upd.frame.next_node = {1'b0, upd.ctrl_node};
                                upd.frame.tag       = chn_pkg::TAG_ANN_ACK;
                                upd.frame.ready     = 1'b1;
                            end
                        end
                        chn_pkg::MODE_STEADY:
                        begin
                            if (tagged_me)
                            begin
                                upd.frame.emit      = 1'b1;
                                upd.frame.sender    = emulated_node;
                                upd.frame.next_node = {1'b0, upd.ctrl_node};
                                upd.frame.tag       = chn_pkg::TAG_STEADY;
                                upd.frame.ready     = 1'b1;
                            end
                            else if (second_byte != chn_pkg::TAG_STEADY)
                            begin
                                // drop the sender from the map and fall back
                                if (st.in_range && bit_mid)
                                begin
                                    upd.map_wr  = 1'b1;
                                    upd.map_val = 1'b0;
                                    upd.count   = upd.count - 8'd1;
                                end
                                upd.mode  = chn_pkg::MODE_POWERING;
                                upd.frame = start_frame(chn_pkg::MODE_POWERING,
                                                        emulated_node);
                            end
                        end
                        default:
                        begin
                            upd.mode = st.mode;
                        end
                    endcase
                end
            end
        end

        if (upd.frame.emit)
        begin
            upd.elapsed = 16'd0;
        end
    end

endmodule

/* rtl/can_handshake_node_emulator.sv */
// ----------------------------------------------------------------------------
// can_handshake_node_emulator: one node of a chained CAN handshake
// Flow: an item is captured in the input register, resolved against the state
// registers by single-level step logic, and any requested frame is loaded into
// the result register, from which it transfers.
// Throughput: one item per cycle while the result channel is not stalled.
// Reset (rst_n low, asynchronous): mode powering up, controller node 0, map and
// count clear, timer 0, period 1000 ms, emulated node 98; both stages empty.
// ----------------------------------------------------------------------------
module can_handshake_node_emulator
#(
    parameter int NODE_COUNT = chn_pkg::NODE_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [10:0] frame_id,
    input  logic [7:0]  first_byte,
    input  logic [7:0]  second_byte,
    input  logic        bus_idle,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] out_frame_id,
    output logic [7:0]  next_node,
    output logic [7:0]  out_tag,
    output logic        ready_res
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    // configuration registers
    logic [15:0] period_reg;
    logic [6:0]  emu_node_reg;

    // input register: one item waiting for the step logic
    logic        in_vld_reg;
    logic        act_reg;
    logic [10:0] fid_reg;
    logic [7:0]  b0_reg;
    logic [7:0]  b1_reg;
    logic        idle_reg;

    // handshake state
    chn_pkg::mode_t       mode_reg;
    logic [6:0]           ctrl_reg;
    logic [7:0]           count_reg;
    logic [15:0]          elapsed_reg;
    logic [NODE_COUNT-1:0] map_reg;

    // result register
    logic        res_vld_reg;
    logic [10:0] res_id_reg;
    logic [7:0]  res_next_reg;
    logic [7:0]  res_tag_reg;
    logic        res_ready_reg;

    logic            advance;
    logic            take_in;
    logic            process;
    logic [6:0]      node;
    logic            in_range;
    logic [IDX_W-1:0] map_idx;
    chn_pkg::state_t st;
    chn_pkg::upd_t   upd;

    // The stage moves on whenever the result slot is empty or being taken.
    assign advance  = !res_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;
    assign take_in  = in_valid && !in_stall;
    assign process  = in_vld_reg && advance;

    // Sender's node id; ids beyond the map never touch it.
    assign node     = fid_reg[6:0];
    assign in_range = {1'b0, node} < 8'(NODE_COUNT);
    assign map_idx  = node[IDX_W-1:0];

    assign st.mode      = mode_reg;
    assign st.ctrl_node = ctrl_reg;
    assign st.count     = count_reg;
    assign st.elapsed   = elapsed_reg;
    assign st.map_bit   = in_range && map_reg[map_idx];
    assign st.in_range  = in_range;

    chn_step u_step
    (
        .action           (act_reg),
        .frame_id         (fid_reg),
        .first_byte       (b0_reg),
        .second_byte      (b1_reg),
        .bus_idle         (idle_reg),
        .st               (st),
        .handshake_period (period_reg),
        .emulated_node    (emu_node_reg),
        .upd              (upd)
    );

    // Configuration: a node write keeps only the low seven bits of the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= chn_pkg::PERIOD_RESET;
            emu_node_reg <= chn_pkg::NODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                chn_pkg::CFG_PERIOD:
                begin
                    period_reg <= cfg_data;
                end
                chn_pkg::CFG_NODE:
                begin
                    emu_node_reg <= cfg_data[6:0];
                end
                default:
                begin
                    period_reg <= period_reg;
                end
            endcase
        end
    end

    // Input register control: fill on a transfer, empty when the step runs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // Input payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            act_reg  <= action;
            fid_reg  <= frame_id;
            b0_reg   <= first_byte;
            b1_reg   <= second_byte;
            idle_reg <= bus_idle;
        end
    end

    // Handshake state: commit the step's update once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= chn_pkg::MODE_POWERING;
            ctrl_reg    <= 7'd0;
            count_reg   <= 8'd0;
            elapsed_reg <= 16'd0;
            map_reg     <= '0;
        end
        else if (process)
        begin
            mode_reg    <= upd.mode;
            ctrl_reg    <= upd.ctrl_node;
            count_reg   <= upd.count;
            elapsed_reg <= upd.elapsed;
            if (upd.map_wr && in_range)
            begin
                map_reg[map_idx] <= upd.map_val;
            end
        end
    end

    // Result register: load a requested frame, drop it once transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= process && upd.frame.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && upd.frame.emit)
        begin
            res_id_reg    <= chn_pkg::FUNC_HANDSHAKE | {4'd0, upd.frame.sender};
            res_next_reg  <= upd.frame.next_node;
            res_tag_reg   <= upd.frame.tag;
            res_ready_reg <= upd.frame.ready;
        end
    end

    assign out_valid    = res_vld_reg;
    assign out_frame_id = res_id_reg;
    assign next_node    = res_next_reg;
    assign out_tag      = res_tag_reg;
    assign ready_res    = res_ready_reg;

    // The count always matches the number of announced nodes in the map.
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(map_reg)) == 32'(count_reg))
        else $error("announced count differs from map population");

    // Every requested frame carries the handshake function code.
    a_result_func_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_frame_id & chn_pkg::FUNC_MASK) == chn_pkg::FUNC_HANDSHAKE))
        else $error("result frame id outside the handshake range");

    // Only the announce tag goes out without the ready byte.
    a_ready_vs_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ready_res == (out_tag != chn_pkg::TAG_ANNOUNCE)))
        else $error("ready flag inconsistent with tag");

    // A request restarts the period timer.
    a_request_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (process && upd.frame.emit) |=> (elapsed_reg == 16'd0))
        else $error("timer not restarted after a request");

    // Input holds off only behind a result that is itself held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && in_vld_reg))
        else $error("input stalled without a blocked result");

endmodule

/* sim/chn_handshake_checker.sv */
// ----------------------------------------------------------------------------
// chn_handshake_checker: scoreboard for the CAN handshake node emulator
// Tracks configuration writes and input transfers, predicts each requested
// handshake frame and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
module chn_handshake_checker
#(
    parameter int NODE_COUNT = chn_pkg::NODE_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        action,
    input  logic [10:0] frame_id,
    input  logic [7:0]  first_byte,
    input  logic [7:0]  second_byte,
    input  logic        bus_idle,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [10:0] out_frame_id,
    input  logic [7:0]  next_node,
    input  logic [7:0]  out_tag,
    input  logic        ready_res,
    output int          mismatches,
    output int          frames_due
);

    typedef struct packed {
        logic        hit;
        logic [10:0] id;
        logic [7:0]  next;
        logic [7:0]  tag;
        logic        ready;
    } hs_req_t;

    // frames predicted but not yet seen; two stages bound the backlog
    localparam int DUE_DEPTH = 8;

    logic [15:0]           period;
    logic [6:0]            own_node;
    chn_pkg::mode_t        mode;
    logic [6:0]            ctrl;
    logic [NODE_COUNT-1:0] seen;
    logic [7:0]            seen_count;
    logic [15:0]           elapsed;

    hs_req_t               due_fifo [DUE_DEPTH];
    logic [2:0]            due_rd;
    logic [2:0]            due_wr;
    int                    due_cnt;
    hs_req_t               want;
    hs_req_t               made;
    int                    n_bad = 0;

    // every request restarts the silence timer
    function automatic hs_req_t request_frame(input logic [6:0] sender,
                                              input logic [7:0] next,
                                              input logic [7:0] tag,
                                              input logic       ready);
        hs_req_t r;
        r.hit   = 1'b1;
        r.id    = chn_pkg::FUNC_HANDSHAKE + {4'd0, sender};
        r.next  = next;
        r.tag   = tag;
        r.ready = ready;
        elapsed = '0;
        return r;
    endfunction

    function automatic hs_req_t start_round();
        if (mode == chn_pkg::MODE_POWERING)
            return request_frame(7'd0, 8'd0, chn_pkg::TAG_ANNOUNCE, 1'b0);
        return request_frame(7'd0, {1'b0, own_node}, chn_pkg::TAG_START, 1'b1);
    endfunction

    function automatic hs_req_t on_frame(input logic [6:0] node,
                                         input logic [7:0] chain_next,
                                         input logic [7:0] tag);
        hs_req_t none;
        logic    known;
        none  = '0;
        known = (int'(node) < NODE_COUNT);
        if (node != 7'd0 && node != own_node)
            ctrl = node;

        // a node announcing itself
        if ({1'b0, node} == chain_next && tag == chn_pkg::TAG_ANNOUNCE)
        begin
            if (known && !seen[node])
            begin
                seen[node] = 1'b1;
                seen_count = seen_count + 8'd1;
            end
            if (seen_count > chn_pkg::COUNT_THRESHOLD)
            begin
                mode = chn_pkg::MODE_ANNOUNCED;
                return start_round();
            end
        end

        if (chain_next == 8'd0 &&
            (tag == chn_pkg::TAG_ANN_ACK || tag == chn_pkg::TAG_STEADY))
        begin
            if (mode != chn_pkg::MODE_STEADY)
            begin
                mode = chn_pkg::MODE_STEADY;
                return start_round();
            end
            return none;
        end

        case (mode)
            chn_pkg::MODE_POWERING:
                if (node == 7'd0)
                    return request_frame(own_node, {1'b0, own_node},
                                         chn_pkg::TAG_ANNOUNCE, 1'b0);
            chn_pkg::MODE_ANNOUNCED:
                if (chain_next == {1'b0, own_node})
                    return request_frame(own_node, {1'b0, ctrl},
                                         chn_pkg::TAG_ANN_ACK, 1'b1);
            chn_pkg::MODE_STEADY:
            begin
                if (chain_next == {1'b0, own_node})
                    return request_frame(own_node, {1'b0, ctrl},
                                         chn_pkg::TAG_STEADY, 1'b1);
                // chain broken: drop the sender and fall back to powering up
                if (tag != chn_pkg::TAG_STEADY)
                begin
                    if (known && seen[node])
                    begin
                        seen[node] = 1'b0;
                        seen_count = seen_count - 8'd1;
                    end
                    mode = chn_pkg::MODE_POWERING;
                    return start_round();
                end
            end
            default: ;
        endcase
        return none;
    endfunction

    function automatic hs_req_t resolve_item();
        hs_req_t none;
        none = '0;
        if (action)
        begin
            if (elapsed != chn_pkg::ELAPSED_MAX)
                elapsed = elapsed + 16'd1;
            if (bus_idle && elapsed > period)
                return start_round();
            return none;
        end
        if ((frame_id & chn_pkg::FUNC_MASK) != chn_pkg::FUNC_HANDSHAKE)
            return none;
        return on_frame(frame_id[6:0], first_byte, second_byte);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period     = chn_pkg::PERIOD_RESET;
            own_node   = chn_pkg::NODE_RESET;
            mode       = chn_pkg::MODE_POWERING;
            ctrl       = '0;
            seen       = '0;
            seen_count = '0;
            elapsed    = '0;
            due_rd     = '0;
            due_wr     = '0;
            due_cnt    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == chn_pkg::CFG_PERIOD)
                    period = cfg_data;
                else
                    own_node = cfg_data[6:0];
            end

            if (out_valid && !out_stall)
            begin
                if (due_cnt == 0)
                begin
                    $error("unexpected result: out_frame_id %0h next_node %0h out_tag %0h",
                           out_frame_id, next_node, out_tag);
                    n_bad++;
                end
                else
                begin
                    want    = due_fifo[due_rd];
                    due_rd  = due_rd + 3'd1;
                    due_cnt = due_cnt - 1;
                    if (out_frame_id !== want.id)
                    begin
                        $error("out_frame_id: expected %0h, got %0h", want.id, out_frame_id);
                        n_bad++;
                    end
                    if (next_node !== want.next)
                    begin
                        $error("next_node: expected %0h, got %0h", want.next, next_node);
                        n_bad++;
                    end
                    if (out_tag !== want.tag)
                    begin
                        $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
                        n_bad++;
                    end
                    if (ready_res !== want.ready)
                    begin
                        $error("ready_res: expected %0b, got %0b", want.ready, ready_res);
                        n_bad++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                made = resolve_item();
                if (made.hit)
                begin
                    if (due_cnt == DUE_DEPTH)
                    begin
                        $error("too many frames outstanding");
                        n_bad++;
                    end
                    else
                    begin
                        due_fifo[due_wr] = made;
                        due_wr           = due_wr + 3'd1;
                        due_cnt          = due_cnt + 1;
                    end
                end
            end
        end
        frames_due <= due_cnt;
        mismatches <= n_bad;
    end

endmodule

/* sim/tb_can_handshake_node_emulator.sv */
// ----------------------------------------------------------------------------
// tb_can_handshake_node_emulator: testbench for the CAN handshake node emulator
// Drives directed and random frame and tick transfers through several register
// settings and idling patterns; a side checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_can_handshake_node_emulator;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = chn_pkg::CFG_PERIOD;
    logic [15:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        action      = 1'b0;
    logic [10:0] frame_id    = '0;
    logic [7:0]  first_byte  = '0;
    logic [7:0]  second_byte = '0;
    logic        bus_idle    = 1'b0;
    logic        out_stall   = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [10:0] out_frame_id;
    logic [7:0]  next_node;
    logic [7:0]  out_tag;
    logic        ready_res;

    int          mismatches;
    int          frames_due;

    // idling odds in percent, changed between phases
    int          send_gap_pct   = 37;
    int          sink_stall_pct = 84;
    // our copy of the emulated node, used to aim frames at the block
    logic [6:0]  own_node       = chn_pkg::NODE_RESET;

    can_handshake_node_emulator u_top (.*);

    chn_handshake_checker u_check (.*);

    always #1 clk = ~clk;

    // receiver side: stall at random, one decision per cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < sink_stall_pct);

    // Present one item, idling first at random, and hold it until the transfer.
    // Valid stays high on return so a following item can go out back to back.
    task automatic push_item(input logic        act,
                             input logic [10:0] fid,
                             input logic [7:0]  b0,
                             input logic [7:0]  b1,
                             input logic        idle);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        frame_id    <= fid;
        first_byte  <= b0;
        second_byte <= b1;
        bus_idle    <= idle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid, wait for every predicted frame, then let the pipeline
    // drain of items that cause nothing.
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == chn_pkg::CFG_NODE)
            own_node = data[6:0];
    endtask

    // data byte 0: favour values that steer the chain
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return {1'b0, own_node};
            2:       return 8'($urandom_range(7));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_tag();
        case ($urandom_range(5))
            0:       return chn_pkg::TAG_ANNOUNCE;
            1:       return chn_pkg::TAG_START;
            2:       return chn_pkg::TAG_ANN_ACK;
            3, 4:    return chn_pkg::TAG_STEADY;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed handshake traffic with random content, plus ticks
    // and a slice of raw noise.
    task automatic random_item();
        int          pick;
        logic [6:0]  node;
        logic        idle;
        logic [10:0] hs_id;
        pick = $urandom_range(99);
        node = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(6));
        if ($urandom_range(7) == 0)
            node = own_node;
        idle  = 1'($urandom);
        hs_id = chn_pkg::FUNC_HANDSHAKE | {4'd0, node};
        if (pick < 25)
            push_item(1'b1, 11'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(3) != 0);
        else if (pick < 45)
            push_item(1'b0, hs_id, {1'b0, node}, chn_pkg::TAG_ANNOUNCE, idle);
        else if (pick < 55)
            push_item(1'b0, hs_id, 8'd0,
                      $urandom_range(1) ? chn_pkg::TAG_ANN_ACK : chn_pkg::TAG_STEADY, idle);
        else if (pick < 70)
            push_item(1'b0, hs_id, {1'b0, own_node}, pick_tag(), idle);
        else if (pick < 80)
            push_item(1'b0, chn_pkg::FUNC_HANDSHAKE, pick_byte(), pick_tag(), idle);
        else if (pick < 92)
            push_item(1'b0, hs_id, pick_byte(), pick_tag(), idle);
        else
            push_item(1'b0, 11'($urandom), 8'($urandom), 8'($urandom), idle);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset settings: period 1000, emulated node 98
        push_item(1'b0, 11'h000, 8'h00, 8'h00, 1'b0);      // not a handshake frame
        push_item(1'b0, 11'h7FF, 8'hFF, 8'hFF, 1'b1);      // all ones, wrong function code
        push_item(1'b1, 11'h7FF, 8'hFF, 8'hFF, 1'b0);      // tick on a busy bus
        push_item(1'b0, 11'h480, 8'h00, chn_pkg::TAG_ANNOUNCE, 1'b0); // controller announces
        push_item(1'b0, 11'h485, 8'h05, chn_pkg::TAG_ANNOUNCE, 1'b0);
        push_item(1'b0, 11'h4FF, 8'h7F, chn_pkg::TAG_ANNOUNCE, 1'b0); // third node: announced
        push_item(1'b0, 11'h487, 8'd98, chn_pkg::TAG_START, 1'b0);  // we are next in chain
        push_item(1'b0, 11'h487, 8'hC8, chn_pkg::TAG_ANNOUNCE, 1'b0); // next node out of range
        push_item(1'b0, 11'h487, 8'h00, chn_pkg::TAG_ANN_ACK, 1'b0); // into steady state
        push_item(1'b0, 11'h487, 8'h00, chn_pkg::TAG_STEADY, 1'b0); // already steady
        push_item(1'b0, 11'h490, 8'd98, 8'h33, 1'b0);
        push_item(1'b0, 11'h4FF, 8'h09, chn_pkg::TAG_STEADY, 1'b0);
        push_item(1'b0, 11'h4FF, 8'h09, 8'h33, 1'b0);      // chain broken
        push_item(1'b0, 11'h480, 8'h80, 8'h80, 1'b1);      // bus_idle ignored on a frame
        push_item(1'b1, 11'h000, 8'h00, 8'h00, 1'b1);      // idle tick, period far off
        wait_for_quiet();

        // zero period; node value with high bits set keeps only the low seven
        write_reg(chn_pkg::CFG_PERIOD, 16'd0);
        write_reg(chn_pkg::CFG_NODE, 16'hFF81);
        push_item(1'b1, 11'h000, 8'h00, 8'h00, 1'b0);
        push_item(1'b1, 11'h000, 8'h00, 8'h00, 1'b1);
        push_item(1'b1, 11'h000, 8'h00, 8'h00, 1'b1);
        push_item(1'b0, 11'h480, 8'h00, chn_pkg::TAG_STEADY, 1'b0);
        push_item(1'b0, 11'h481, 8'h01, chn_pkg::TAG_ANNOUNCE, 1'b0); // our own echo
        wait_for_quiet();

        // random phases: two under each idling pattern
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(chn_pkg::CFG_PERIOD, 16'd0);
                    write_reg(chn_pkg::CFG_NODE, 16'd127);
                end
                1:
                begin
                    // longest period: never expires within this phase
                    write_reg(chn_pkg::CFG_PERIOD, 16'hFFFF);
                    write_reg(chn_pkg::CFG_NODE, 16'($urandom_range(1, 127)));
                end
                2:
                begin
                    send_gap_pct   = 84;
                    sink_stall_pct = 37;
                    write_reg(chn_pkg::CFG_PERIOD, 16'($urandom_range(15)));
                    write_reg(chn_pkg::CFG_NODE, 16'd0);
                end
                3:
                begin
                    write_reg(chn_pkg::CFG_PERIOD, 16'($urandom_range(40)));
                    write_reg(chn_pkg::CFG_NODE, 16'(chn_pkg::NODE_RESET));
                end
                4:
                begin
                    send_gap_pct   = 0;
                    sink_stall_pct = 0;
                    write_reg(chn_pkg::CFG_PERIOD, 16'($urandom_range(20)));
                    write_reg(chn_pkg::CFG_NODE, 16'($urandom));
                end
                default:
                begin
                    write_reg(chn_pkg::CFG_PERIOD, 16'd3);
                    write_reg(chn_pkg::CFG_NODE, 16'($urandom_range(1, 127)));
                end
            endcase
            repeat (150) random_item();
            wait_for_quiet();
        end

        if (mismatches == 0 && frames_due == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* can_handshake_node_emulator.f */
rtl/chn_pkg.sv
rtl/chn_step.sv
rtl/can_handshake_node_emulator.sv
sim/chn_handshake_checker.sv
sim/tb_can_handshake_node_emulator.sv
